[rtl/vhs_pkg.sv]
// vacuum hose sequencer package: state codes, register map and config struct
package vhs_pkg;

  localparam int unsigned STATE_W = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [STATE_W-1:0] {
    ST_LISTEN    = 4'd0,
    ST_VAC_UP    = 4'd1,
    ST_SERVO_UP  = 4'd2,
    ST_ACTION    = 4'd3,
    ST_SERVO_DN  = 4'd4,
    ST_VACUUMING = 4'd5,
    ST_VAC_DN    = 4'd6,
    ST_POST_UP   = 4'd7,
    ST_STANDBY   = 4'd8,
    ST_POST_DN   = 4'd9
  } state_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VAC_PWR   = 2'd0,
    REG_SERVO_PWR = 2'd1,
    REG_SERVO_MOV = 2'd2
  } reg_idx_e;

  localparam logic [DELAY_W-1:0] VAC_PWR_RST   = 16'd1000;
  localparam logic [DELAY_W-1:0] SERVO_PWR_RST = 16'd500;
  localparam logic [DELAY_W-1:0] SERVO_MOV_RST = 16'd1000;

  typedef struct packed {
    logic [DELAY_W-1:0] vac_power_delay;
    logic [DELAY_W-1:0] servo_power_delay;
    logic [DELAY_W-1:0] servo_move_delay;
  } cfg_t;

endpackage

[rtl/vhs_fsm.sv]
// vacuum hose sequencer state machine, one tick per step strobe
module vhs_fsm #(
  parameter int unsigned PORT_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  vhs_pkg::cfg_t                cfg_i,
  input  logic [vhs_pkg::TIME_W-1:0]   now_ms_i,
  input  logic                         node_active_i,
  input  logic [PORT_BITS-1:0]         node_port_i,
  output vhs_pkg::state_e              state_o,
  output logic                         vacuum_on_o,
  output logic                         servo_on_o,
  output logic [PORT_BITS-1:0]         servo_target_o
);

  vhs_pkg::state_e               state_q, state_d;
  logic [vhs_pkg::TIME_W-1:0]    last_q, last_d;
  logic [PORT_BITS-1:0]          node_q, node_d;
  logic                          vac_q, vac_d;
  logic                          servo_q, servo_d;
  logic [PORT_BITS-1:0]          target_q, target_d;

  logic [vhs_pkg::TIME_W-1:0]    elapsed;
  logic                          to_vac, to_servo_pwr, to_servo_mov;
  logic                          same;

  assign elapsed      = now_ms_i - last_q;
  assign to_vac       = elapsed > {16'd0, cfg_i.vac_power_delay};
  assign to_servo_pwr = elapsed > {16'd0, cfg_i.servo_power_delay};
  assign to_servo_mov = elapsed > {16'd0, cfg_i.servo_move_delay};
  assign same         = node_port_i == node_q;

  always_comb begin
    vhs_pkg::state_e nxt;
    logic            chg;
    nxt      = state_q;
    chg      = 1'b0;
    node_d   = node_q;
    vac_d    = vac_q;
    servo_d  = servo_q;
    target_d = target_q;
    case (state_q)
      vhs_pkg::ST_LISTEN: begin
        node_d = node_active_i ? node_port_i : '0;
        if (node_active_i) begin
          nxt = vhs_pkg::ST_VAC_UP;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_VAC_UP: begin
        if (node_active_i) begin
          vac_d = 1'b1;
          if (to_vac) begin
            nxt = vhs_pkg::ST_SERVO_UP;
            chg = 1'b1;
          end
        end else begin
          nxt = vhs_pkg::ST_VAC_DN;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_SERVO_UP: begin
        if (node_active_i) begin
          servo_d = 1'b1;
          if (to_servo_pwr) begin
            nxt = vhs_pkg::ST_ACTION;
            chg = 1'b1;
          end
        end else begin
          nxt = vhs_pkg::ST_POST_DN;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_ACTION: begin
        if (node_active_i) begin
          target_d = node_port_i;
          if (same && to_servo_mov) begin
            nxt = vhs_pkg::ST_SERVO_DN;
            chg = 1'b1;
          end
        end else begin
          nxt = vhs_pkg::ST_STANDBY;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_SERVO_DN: begin
        if (node_active_i) begin
          servo_d = 1'b0;
          if (same && to_servo_pwr) begin
            nxt = vhs_pkg::ST_VACUUMING;
            chg = 1'b1;
          end
        end else begin
          nxt = vhs_pkg::ST_POST_UP;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_VACUUMING: begin
        if (node_active_i) begin
          if (!same) begin
            node_d = node_port_i;
            nxt    = vhs_pkg::ST_SERVO_UP;
            chg    = 1'b1;
          end
        end else begin
          nxt = vhs_pkg::ST_VAC_DN;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_VAC_DN: begin
        vac_d = 1'b0;
        if (to_vac) begin
          nxt = vhs_pkg::ST_POST_UP;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_POST_UP: begin
        servo_d = 1'b1;
        if (to_servo_pwr) begin
          nxt = vhs_pkg::ST_STANDBY;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_STANDBY: begin
        target_d = '0;
        if (to_servo_mov) begin
          nxt = vhs_pkg::ST_POST_DN;
          chg = 1'b1;
        end
      end
      vhs_pkg::ST_POST_DN: begin
        servo_d = 1'b0;
        if (to_servo_pwr) begin
          vac_d = 1'b0;
          nxt   = vhs_pkg::ST_LISTEN;
          chg   = 1'b1;
        end
      end
      default: begin
        servo_d = 1'b0;
        vac_d   = 1'b0;
        nxt     = vhs_pkg::ST_LISTEN;
        chg     = 1'b1;
      end
    endcase
    state_d = nxt;
    last_d  = chg ? now_ms_i : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vhs_pkg::ST_LISTEN;
      last_q   <= '0;
      node_q   <= '0;
      vac_q    <= 1'b0;
      servo_q  <= 1'b0;
      target_q <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      last_q   <= last_d;
      node_q   <= node_d;
      vac_q    <= vac_d;
      servo_q  <= servo_d;
      target_q <= target_d;
    end
  end

  assign state_o        = state_q;
  assign vacuum_on_o    = vac_q;
  assign servo_on_o     = servo_q;
  assign servo_target_o = target_q;

endmodule

[rtl/vacuum_hose_sequencer_top.sv]
// vacuum hose sequencer top level: stream ports, input register, config registers
//
//   channel   | dir | handshake         | payload
//   s_axis    | in  | tvalid / tready   | tick word: now_ms, node_active, node_port
//   m_axis    | out | tvalid / tready   | result word: seq_state, vacuum_on, servo_on,
//             |     |                   | servo_target
//   apb       | in  | psel/penable      | three 16-bit delay registers at 0x0, 0x4, 0x8
//
// one word per cycle sustained while m_axis is ready; a tick word waits in the input
// register and its result appears on m_axis from the state registers, which double as
// the result register. reset returns to listening with all delays at their defaults.
// with m_axis stalled one further tick word is held in the input register, then
// s_axis_tready drops.
module vacuum_hose_sequencer_top #(
  parameter  int unsigned PORT_BITS   = 4,
  localparam int unsigned IN_W        = vhs_pkg::TIME_W + 1 + PORT_BITS,
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W       = vhs_pkg::STATE_W + 2 + PORT_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // now_ms, node_active, node_port, zero fill
  input  logic [IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // seq_state, vacuum_on, servo_on, servo_target, zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vhs_pkg::APB_AW-1:0]  paddr,
  input  logic [vhs_pkg::APB_DW-1:0]  pwdata,
  output logic [vhs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned TW = vhs_pkg::TIME_W;

  vhs_pkg::cfg_t              cfg_q, cfg_d;
  logic                       in_valid_q, in_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic [TW-1:0]              now_q;
  logic                       active_q;
  logic [PORT_BITS-1:0]       port_q;
  logic                       s_accept, advance, step, cfg_wr;
  vhs_pkg::state_e            seq_state;
  logic                       vacuum_on, servo_on;
  logic [PORT_BITS-1:0]       servo_target;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign advance  = !out_valid_q || m_axis_tready;
  assign step     = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        vhs_pkg::REG_VAC_PWR:   cfg_d.vac_power_delay   = pwdata[15:0];
        vhs_pkg::REG_SERVO_PWR: cfg_d.servo_power_delay = pwdata[15:0];
        vhs_pkg::REG_SERVO_MOV: cfg_d.servo_move_delay  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vhs_pkg::REG_VAC_PWR:   prdata = {16'd0, cfg_q.vac_power_delay};
      vhs_pkg::REG_SERVO_PWR: prdata = {16'd0, cfg_q.servo_power_delay};
      vhs_pkg::REG_SERVO_MOV: prdata = {16'd0, cfg_q.servo_move_delay};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    in_valid_d  = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_q);
    out_valid_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vac_power_delay   <= vhs_pkg::VAC_PWR_RST;
      cfg_q.servo_power_delay <= vhs_pkg::SERVO_PWR_RST;
      cfg_q.servo_move_delay  <= vhs_pkg::SERVO_MOV_RST;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      now_q    <= s_axis_tdata[TW-1:0];
      active_q <= s_axis_tdata[TW];
      port_q   <= s_axis_tdata[TW+1 +: PORT_BITS];
    end
  end

  vhs_fsm #(
    .PORT_BITS(PORT_BITS)
  ) u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .now_ms_i       (now_q),
    .node_active_i  (active_q),
    .node_port_i    (port_q),
    .state_o        (seq_state),
    .vacuum_on_o    (vacuum_on),
    .servo_on_o     (servo_on),
    .servo_target_o (servo_target)
  );

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[vhs_pkg::STATE_W-1:0]               = seq_state;
    m_axis_tdata[vhs_pkg::STATE_W]                   = vacuum_on;
    m_axis_tdata[vhs_pkg::STATE_W+1]                 = servo_on;
    m_axis_tdata[vhs_pkg::STATE_W+2 +: PORT_BITS]    = servo_target;
  end

  a_listen_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_state == vhs_pkg::ST_LISTEN |-> !vacuum_on && !servo_on)
    else $error("power left on while listening");

  a_vacuuming_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_state == vhs_pkg::ST_VACUUMING |-> vacuum_on && !servo_on)
    else $error("wrong power levels while vacuuming");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room to spare");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> !$past(step) && $stable(seq_state))
    else $error("pending result overwritten");

endmodule
